### rtl/smau_pkg.sv
package smau_pkg;

    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int OP_W        = 3;
    localparam int DIM_REG_W   = 4;
    localparam int CFG_INDEX_W = 3;

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);
    localparam logic [DATA_W-1:0] SAT_MAX    = {1'b0, {(DATA_W - 1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN    = {1'b1, {(DATA_W - 1){1'b0}}};

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_OPERATION    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS_A       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COLS_A       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COLS_B       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_FACTOR = 3'd4;

    typedef enum logic [OP_W-1:0] {
        OP_ADD       = 3'd0,
        OP_SUB       = 3'd1,
        OP_MUL       = 3'd2,
        OP_SCALE     = 3'd3,
        OP_TRANSPOSE = 3'd4
    } op_t;

    typedef struct packed {
        logic [OP_W-1:0]      operation;
        logic [DIM_REG_W-1:0] rows_a;
        logic [DIM_REG_W-1:0] cols_a;
        logic [DIM_REG_W-1:0] cols_b;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic we_a;
        logic we_b;
        logic issue;
        logic acc_first;
        logic acc_done;
        logic last;
        op_t  op;
    } smau_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pipe_idle;
    } dp_status_t;

    // Unused codes behave as add
    function automatic op_t decode_op(input logic [OP_W-1:0] code);
        op_t op;
        unique case (code)
            OP_SUB:       op = OP_SUB;
            OP_MUL:       op = OP_MUL;
            OP_SCALE:     op = OP_SCALE;
            OP_TRANSPOSE: op = OP_TRANSPOSE;
            default:      op = OP_ADD;
        endcase
        return op;
    endfunction

endpackage

### rtl/small_matrix_arithmetic_unit.sv
// Small matrix arithmetic unit: A+B, A-B, A*B, k*A or transpose(A) on signed
// Q16.16 matrices of up to MAX_DIM x MAX_DIM elements.
//
// Request channel: present element_value and to_matrix_b with start high; the
// element is taken at a rising edge where start is high and busy is low. One
// element per cycle while loading, row-major, A and B interleaved freely.
// Surplus elements, and B elements for scale or transpose, are dropped.
// The request that completes the operands raises busy on the next cycle.
// Result channel: result_valid strobes for one cycle per element, row-major,
// with last on the final one. The receiver cannot stall it.
// After the completing request, reads pass the RAM read, product or sum,
// accumulate and round stages. Throughput: one read pair per cycle from the
// operand RAMs, one per element-wise or transpose result and one per
// multiply-accumulate of a product. Busy drops once the pipeline has drained.
// Configuration writes are taken at any time but are meant for idle.
// Reset: load counts clear, registers take their defaults (add, 8x8x8, k = 1.0);
// the operand RAMs are not cleared and need no clearing pass.
module small_matrix_arithmetic_unit
    import smau_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] element_value,
    input  logic                     to_matrix_b,
    output logic                     result_valid,
    output logic signed [DATA_W-1:0] result_value,
    output logic                     last,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [DATA_W-1:0]        cfg_data
);

    localparam int AW = $clog2(MAX_DIM * MAX_DIM);

    // Configuration registers
    logic [OP_W-1:0]          operation_reg, operation_next;
    logic [DIM_REG_W-1:0]     rows_a_reg, rows_a_next;
    logic [DIM_REG_W-1:0]     cols_a_reg, cols_a_next;
    logic [DIM_REG_W-1:0]     cols_b_reg, cols_b_next;
    logic signed [DATA_W-1:0] scale_factor_reg, scale_factor_next;

    cfg_t          cfg;
    smau_cmd_t     cmd;
    dp_status_t    status;
    logic [AW-1:0] wr_addr, rd_a_addr, rd_b_addr;

    // Writes are always taken; indexes beyond the register list are ignored
    assign cfg_ready = 1'b1;

    always_comb
    begin
        operation_next    = operation_reg;
        rows_a_next       = rows_a_reg;
        cols_a_next       = cols_a_reg;
        cols_b_next       = cols_b_reg;
        scale_factor_next = scale_factor_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_OPERATION:    operation_next    = cfg_data[OP_W-1:0];
                REG_ROWS_A:       rows_a_next       = cfg_data[DIM_REG_W-1:0];
                REG_COLS_A:       cols_a_next       = cfg_data[DIM_REG_W-1:0];
                REG_COLS_B:       cols_b_next       = cfg_data[DIM_REG_W-1:0];
                REG_SCALE_FACTOR: scale_factor_next = cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            operation_reg    <= OP_ADD;
            rows_a_reg       <= DIM_REG_W'(8);
            cols_a_reg       <= DIM_REG_W'(8);
            cols_b_reg       <= DIM_REG_W'(8);
            // 1.0 in Q16.16
            scale_factor_reg <= DATA_W'(1) << FRAC_W;
        end
        else
        begin
            operation_reg    <= operation_next;
            rows_a_reg       <= rows_a_next;
            cols_a_reg       <= cols_a_next;
            cols_b_reg       <= cols_b_next;
            scale_factor_reg <= scale_factor_next;
        end
    end

    assign cfg.operation = operation_reg;
    assign cfg.rows_a    = rows_a_reg;
    assign cfg.cols_a    = cols_a_reg;
    assign cfg.cols_b    = cols_b_reg;

    // Load counting, operand completion and the read sequence
    smau_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .to_matrix_b (to_matrix_b),
        .cfg         (cfg),
        .status      (status),
        .busy        (busy),
        .cmd         (cmd),
        .wr_addr     (wr_addr),
        .rd_a_addr   (rd_a_addr),
        .rd_b_addr   (rd_b_addr)
    );

    // Operand RAMs, multiplier, accumulator and rounding
    smau_datapath #(.MAX_DIM(MAX_DIM)) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .wr_addr       (wr_addr),
        .rd_a_addr     (rd_a_addr),
        .rd_b_addr     (rd_b_addr),
        .element_value (element_value),
        .scale_factor  (scale_factor_reg),
        .status        (status),
        .result_valid  (result_valid),
        .result_value  (result_value),
        .last          (last)
    );

endmodule

### rtl/smau_ram.sv
module smau_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/smau_ctrl.sv
module smau_ctrl
    import smau_pkg::*;
#(
    parameter int MAX_DIM = 8,
    localparam int DW     = $clog2(MAX_DIM + 1),
    localparam int AW     = $clog2(MAX_DIM * MAX_DIM),
    localparam int CW     = $clog2(MAX_DIM * MAX_DIM + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          to_matrix_b,
    input  cfg_t          cfg,
    input  dp_status_t    status,
    output logic          busy,
    output smau_cmd_t     cmd,
    output logic [AW-1:0] wr_addr,
    output logic [AW-1:0] rd_a_addr,
    output logic [AW-1:0] rd_b_addr
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_a_reg, count_a_next;
    logic [CW-1:0] count_b_reg, count_b_next;
    logic [DW-1:0] i_reg, i_next;
    logic [DW-1:0] j_reg, j_next;
    logic [DW-1:0] t_reg, t_next;
    logic [AW-1:0] a_addr_reg, a_addr_next;
    logic [AW-1:0] b_addr_reg, b_addr_next;
    logic [AW-1:0] row_base_reg, row_base_next;

    logic [DW-1:0]   r, c, cb;
    logic [DW-1:0]   i_lim, j_lim, t_lim;
    logic [2*DW-1:0] area_a, area_b;
    logic [CW-1:0]   need_a, need_b;
    logic [CW-1:0]   cnt_a_inc, cnt_b_inc;
    op_t             op;
    logic            accept, wr_a, wr_b, complete;
    logic            i_wrap, j_wrap, t_wrap, all_wrap;

    function automatic logic [DW-1:0] clamp_dim(input logic [DIM_REG_W-1:0] d);
        logic [DW-1:0] v;
        priority if (d == '0)
            v = DW'(1);
        else if (d > MAX_DIM)
            v = DW'(MAX_DIM);
        else
            v = DW'(d);
        return v;
    endfunction

    assign r      = clamp_dim(cfg.rows_a);
    assign c      = clamp_dim(cfg.cols_a);
    assign cb     = clamp_dim(cfg.cols_b);
    assign op     = decode_op(cfg.operation);
    assign area_a = r * c;
    assign area_b = c * cb;
    assign need_a = area_a[CW-1:0];

    always_comb
    begin
        unique case (op)
            OP_MUL:
            begin
                need_b = area_b[CW-1:0];
                i_lim  = r;
                j_lim  = cb;
                t_lim  = c;
            end
            OP_TRANSPOSE:
            begin
                need_b = '0;
                i_lim  = c;
                j_lim  = r;
                t_lim  = DW'(1);
            end
            OP_SCALE:
            begin
                need_b = '0;
                i_lim  = r;
                j_lim  = c;
                t_lim  = DW'(1);
            end
            default:
            begin
                need_b = need_a;
                i_lim  = r;
                j_lim  = c;
                t_lim  = DW'(1);
            end
        endcase
    end

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && (state_reg == S_IDLE);
    assign wr_a      = accept && !to_matrix_b && (count_a_reg < need_a);
    assign wr_b      = accept && to_matrix_b && (count_b_reg < need_b);
    assign cnt_a_inc = count_a_reg + CW'(wr_a);
    assign cnt_b_inc = count_b_reg + CW'(wr_b);
    assign complete  = accept && (cnt_a_inc >= need_a) && (cnt_b_inc >= need_b);

    assign t_wrap   = (t_reg == t_lim - DW'(1));
    assign j_wrap   = (j_reg == j_lim - DW'(1));
    assign i_wrap   = (i_reg == i_lim - DW'(1));
    assign all_wrap = t_wrap && j_wrap && i_wrap;

    assign wr_addr   = wr_b ? count_b_reg[AW-1:0] : count_a_reg[AW-1:0];
    assign rd_a_addr = a_addr_reg;
    assign rd_b_addr = b_addr_reg;

    always_comb
    begin
        state_next    = state_reg;
        count_a_next  = count_a_reg;
        count_b_next  = count_b_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        t_next        = t_reg;
        a_addr_next   = a_addr_reg;
        b_addr_next   = b_addr_reg;
        row_base_next = row_base_reg;
        cmd           = '0;
        cmd.op        = op;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd.we_a     = wr_a;
                cmd.we_b     = wr_b;
                count_a_next = cnt_a_inc;
                count_b_next = cnt_b_inc;
                if (complete)
                begin
                    state_next    = S_RUN;
                    count_a_next  = '0;
                    count_b_next  = '0;
                    i_next        = '0;
                    j_next        = '0;
                    t_next        = '0;
                    a_addr_next   = '0;
                    b_addr_next   = '0;
                    row_base_next = '0;
                end
            end
            S_RUN:
            begin
                cmd.issue     = 1'b1;
                cmd.acc_first = (t_reg == '0);
                cmd.acc_done  = t_wrap;
                cmd.last      = all_wrap;

                t_next = t_wrap ? '0 : t_reg + DW'(1);
                if (t_wrap)
                begin
                    j_next = j_wrap ? '0 : j_reg + DW'(1);
                end
                if (t_wrap && j_wrap)
                begin
                    i_next = i_reg + DW'(1);
                end

                unique case (op)
                    OP_MUL:
                    begin
                        // walk a row of A against a column of B
                        if (!t_wrap)
                        begin
                            a_addr_next = a_addr_reg + AW'(1);
                            b_addr_next = b_addr_reg + AW'(cb);
                        end
                        else if (!j_wrap)
                        begin
                            a_addr_next = row_base_reg;
                            b_addr_next = AW'(j_reg) + AW'(1);
                        end
                        else
                        begin
                            row_base_next = row_base_reg + AW'(c);
                            a_addr_next   = row_base_reg + AW'(c);
                            b_addr_next   = '0;
                        end
                    end
                    OP_TRANSPOSE:
                    begin
                        // walk down a column of A
                        if (j_wrap)
                            a_addr_next = AW'(i_reg) + AW'(1);
                        else
                            a_addr_next = a_addr_reg + AW'(c);
                    end
                    default:
                    begin
                        a_addr_next = a_addr_reg + AW'(1);
                        b_addr_next = b_addr_reg + AW'(1);
                    end
                endcase

                if (all_wrap)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (status.pipe_idle)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_a_reg  <= '0;
            count_b_reg  <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            t_reg        <= '0;
            a_addr_reg   <= '0;
            b_addr_reg   <= '0;
            row_base_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_a_reg  <= count_a_next;
            count_b_reg  <= count_b_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            t_reg        <= t_next;
            a_addr_reg   <= a_addr_next;
            b_addr_reg   <= b_addr_next;
            row_base_reg <= row_base_next;
        end
    end

endmodule

### rtl/smau_datapath.sv
module smau_datapath
    import smau_pkg::*;
#(
    parameter int MAX_DIM = 8,
    localparam int AW     = $clog2(MAX_DIM * MAX_DIM)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  smau_cmd_t                cmd,
    input  logic [AW-1:0]            wr_addr,
    input  logic [AW-1:0]            rd_a_addr,
    input  logic [AW-1:0]            rd_b_addr,
    input  logic signed [DATA_W-1:0] element_value,
    input  logic signed [DATA_W-1:0] scale_factor,
    output dp_status_t               status,
    output logic                     result_valid,
    output logic signed [DATA_W-1:0] result_value,
    output logic                     last
);

    localparam int ACC_W = PROD_W + $clog2(MAX_DIM);
    localparam int RND_W = ACC_W - FRAC_W;

    logic [DATA_W-1:0]        a_rdata, b_rdata;
    logic signed [DATA_W-1:0] a_data, b_data, mul_b;
    logic signed [PROD_W-1:0] product;
    logic signed [DATA_W:0]   sum, diff;
    logic [PROD_W-1:0]        term_next;
    logic [ACC_W-1:0]         term_ext, acc_next, rnd_sum;
    logic [RND_W-1:0]         rnd;
    logic                     fits;
    logic [DATA_W-1:0]        sat_value;

    // stage 1: RAM read
    logic s1_v_reg, s1_first_reg, s1_done_reg, s1_last_reg;
    op_t  s1_op_reg;
    // stage 2: product or aligned sum
    logic s2_v_reg, s2_first_reg, s2_done_reg, s2_last_reg;
    logic [PROD_W-1:0] term_reg;
    // stage 3: accumulate
    logic s3_v_reg, s3_done_reg, s3_last_reg;
    logic [ACC_W-1:0] acc_reg;
    // stage 4: round, saturate, present
    logic              result_valid_reg, last_reg;
    logic [DATA_W-1:0] result_value_reg;

    smau_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DIM * MAX_DIM)) u_ram_a (
        .clk   (clk),
        .we    (cmd.we_a),
        .waddr (wr_addr),
        .wdata (element_value),
        .raddr (rd_a_addr),
        .rdata (a_rdata)
    );

    smau_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DIM * MAX_DIM)) u_ram_b (
        .clk   (clk),
        .we    (cmd.we_b),
        .waddr (wr_addr),
        .wdata (element_value),
        .raddr (rd_b_addr),
        .rdata (b_rdata)
    );

    assign a_data  = a_rdata;
    assign b_data  = b_rdata;
    assign mul_b   = (s1_op_reg == OP_MUL) ? b_data : scale_factor;
    assign product = a_data * mul_b;
    assign sum     = a_data + b_data;
    assign diff    = a_data - b_data;

    // add, subtract and transpose are lifted to Q32.32 so one rounding path serves all
    always_comb
    begin
        unique case (s1_op_reg)
            OP_MUL, OP_SCALE:
                term_next = product;
            OP_SUB:
                term_next = {{(PROD_W - DATA_W - 1 - FRAC_W){diff[DATA_W]}}, diff,
                             {FRAC_W{1'b0}}};
            OP_TRANSPOSE:
                term_next = {{(PROD_W - DATA_W - FRAC_W){a_data[DATA_W-1]}}, a_data,
                             {FRAC_W{1'b0}}};
            default:
                term_next = {{(PROD_W - DATA_W - 1 - FRAC_W){sum[DATA_W]}}, sum,
                             {FRAC_W{1'b0}}};
        endcase
    end

    assign term_ext = {{(ACC_W - PROD_W){term_reg[PROD_W-1]}}, term_reg};
    assign acc_next = s2_first_reg ? term_ext : acc_reg + term_ext;

    // round half up, then drop the low 16 fraction bits back to Q16.16 (arithmetic shift keeps the floor)
    assign rnd_sum = acc_reg + ACC_W'(ROUND_HALF);
    assign rnd     = rnd_sum[ACC_W-1:FRAC_W];
    assign fits    = (&rnd[RND_W-1:DATA_W-1]) || !(|rnd[RND_W-1:DATA_W-1]);

    always_comb
    begin
        priority if (fits)
            sat_value = rnd[DATA_W-1:0];
        else if (rnd[RND_W-1])
            sat_value = SAT_MIN;
        else
            sat_value = SAT_MAX;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg         <= 1'b0;
            s1_first_reg     <= 1'b0;
            s1_done_reg      <= 1'b0;
            s1_last_reg      <= 1'b0;
            s1_op_reg        <= OP_ADD;
            s2_v_reg         <= 1'b0;
            s2_first_reg     <= 1'b0;
            s2_done_reg      <= 1'b0;
            s2_last_reg      <= 1'b0;
            s3_v_reg         <= 1'b0;
            s3_done_reg      <= 1'b0;
            s3_last_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
            last_reg         <= 1'b0;
        end
        else
        begin
            s1_v_reg         <= cmd.issue;
            s1_first_reg     <= cmd.acc_first;
            s1_done_reg      <= cmd.acc_done;
            s1_last_reg      <= cmd.last;
            s1_op_reg        <= cmd.op;
            s2_v_reg         <= s1_v_reg;
            s2_first_reg     <= s1_first_reg;
            s2_done_reg      <= s1_done_reg;
            s2_last_reg      <= s1_last_reg;
            s3_v_reg         <= s2_v_reg;
            s3_done_reg      <= s2_done_reg;
            s3_last_reg      <= s2_last_reg;
            result_valid_reg <= s3_v_reg && s3_done_reg;
            last_reg         <= s3_v_reg && s3_done_reg && s3_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_v_reg)
        begin
            term_reg <= term_next;
        end
        if (s2_v_reg)
        begin
            acc_reg <= acc_next;
        end
        if (s3_v_reg && s3_done_reg)
        begin
            result_value_reg <= sat_value;
        end
    end

    assign status.pipe_idle = !(s1_v_reg || s2_v_reg || s3_v_reg);
    assign result_valid     = result_valid_reg;
    assign result_value     = result_value_reg;
    assign last             = last_reg;

endmodule

### rtl/smau_checker.sv
module smau_checker
(
    input logic clk,
    input logic rst_n,
    input logic busy,
    input logic result_valid,
    input logic last
);

    // last only ever marks a delivered result
    a_last_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> result_valid)
        else $error("last without result strobe");

    // results only come out while the block holds off new requests
    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result strobe while idle");

    // the final result releases the block on the next cycle
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |=> !busy)
        else $error("busy held after final result");

    // busy drops only straight after a final result
    a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(result_valid && last))
        else $error("busy dropped before final result");

endmodule

bind small_matrix_arithmetic_unit smau_checker u_smau_checker (.*);
